// ===== src/fsc_pkg.sv =====
// Package for the floating-point stack calculator.
// Holds operation and fault codes, float constants and the controller/datapath
// command and status types. Depends on nothing.
`timescale 1ns / 1ps

package fsc_pkg;

	localparam int STACK_DEPTH_DEF = 8;

	// Instruction codes.
	localparam logic [2:0] OP_PUSH_VAL = 3'd0;
	localparam logic [2:0] OP_PUSH_X   = 3'd1;
	localparam logic [2:0] OP_PUSH_Y   = 3'd2;
	localparam logic [2:0] OP_ADD      = 3'd3;
	localparam logic [2:0] OP_SUB      = 3'd4;
	localparam logic [2:0] OP_MUL      = 3'd5;
	localparam logic [2:0] OP_DIV      = 3'd6;
	localparam logic [2:0] OP_NOP      = 3'd7;

	// Fault codes.
	localparam logic [1:0] FAULT_OK        = 2'd0;
	localparam logic [1:0] FAULT_UNDERFLOW = 2'd1;
	localparam logic [1:0] FAULT_OVERFLOW  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_X = 1'b0;
	localparam logic REG_Y = 1'b1;

	// Float constants.
	localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
	localparam logic [30:0] INF_MAG    = 31'h7F80_0000;
	localparam logic [31:0] X_RESET    = 32'h3FCC_CCCD;
	localparam logic [31:0] Y_RESET    = 32'h3FF3_3333;

	// Working formats: signed exponent and 27-bit significand with guard bits.
	localparam int EXP_W     = 11;
	localparam int MANT_W    = 27;
	localparam int DIV_STEPS = 27;

	typedef enum logic [4:0] {
		DC_NONE,
		DC_LOAD,
		DC_PUSH,
		DC_FAULT_OVF,
		DC_FAULT_UNF,
		DC_START,
		DC_ALIGN,
		DC_PRENORM,
		DC_MUL,
		DC_DIV_INIT,
		DC_DIV_STEP,
		DC_DIV_FIN,
		DC_NORM,
		DC_DENORM,
		DC_ROUND,
		DC_SPECIAL,
		DC_FINISH
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t cmd;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       empty;
		logic       full;
		logic       lt2;
		logic       special;
		logic       pre_done;
		logic       norm_done;
	} sts_t;

endpackage

// ===== src/fsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the stack store. Depends on nothing.
`timescale 1ns / 1ps

module fsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/fsc_ctrl.sv =====
// Sequencer of the floating-point stack calculator.
// Drives one datapath command per cycle from the status it gets back.
// Depends on fsc_pkg.
`timescale 1ns / 1ps

module fsc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  fsc_pkg::sts_t sts,
	output fsc_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_START,
		S_ROUTE,
		S_PRENORM,
		S_MUL,
		S_DIV_INIT,
		S_DIV,
		S_DIV_FIN,
		S_ALIGN,
		S_NORM,
		S_DENORM,
		S_ROUND,
		S_SPECIAL,
		S_FINISH
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q;
	logic       fire;

	assign in_stall = (state_q != S_IDLE);
	assign fire     = (state_q == S_FINISH) && (!out_valid || !out_stall);

	always_comb begin
		state_d = state_q;
		cmd.cmd = fsc_pkg::DC_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cmd = fsc_pkg::DC_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.op inside {fsc_pkg::OP_PUSH_VAL, fsc_pkg::OP_PUSH_X,
						fsc_pkg::OP_PUSH_Y}) begin
					cmd.cmd = sts.full ? fsc_pkg::DC_FAULT_OVF : fsc_pkg::DC_PUSH;
					state_d = S_FINISH;
				end else if (sts.op == fsc_pkg::OP_NOP) begin
					state_d = S_FINISH;
				end else if (sts.lt2) begin
					cmd.cmd = fsc_pkg::DC_FAULT_UNF;
					state_d = S_FINISH;
				end else begin
					state_d = S_START;
				end
			end
			S_START: begin
				cmd.cmd = fsc_pkg::DC_START;
				state_d = S_ROUTE;
			end
			S_ROUTE: begin
				if (sts.special) begin
					state_d = S_SPECIAL;
				end else if (sts.op inside {fsc_pkg::OP_ADD, fsc_pkg::OP_SUB}) begin
					state_d = S_ALIGN;
				end else begin
					state_d = S_PRENORM;
				end
			end
			S_PRENORM: begin
				if (sts.pre_done) begin
					state_d = (sts.op == fsc_pkg::OP_MUL) ? S_MUL : S_DIV_INIT;
				end else begin
					cmd.cmd = fsc_pkg::DC_PRENORM;
				end
			end
			S_MUL: begin
				cmd.cmd = fsc_pkg::DC_MUL;
				state_d = S_NORM;
			end
			S_DIV_INIT: begin
				cmd.cmd = fsc_pkg::DC_DIV_INIT;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.cmd = fsc_pkg::DC_DIV_STEP;
				if (cnt_q == 5'(fsc_pkg::DIV_STEPS - 1)) begin
					state_d = S_DIV_FIN;
				end
			end
			S_DIV_FIN: begin
				cmd.cmd = fsc_pkg::DC_DIV_FIN;
				state_d = S_NORM;
			end
			S_ALIGN: begin
				cmd.cmd = fsc_pkg::DC_ALIGN;
				state_d = S_NORM;
			end
			S_NORM: begin
				if (sts.norm_done) begin
					state_d = S_DENORM;
				end else begin
					cmd.cmd = fsc_pkg::DC_NORM;
				end
			end
			S_DENORM: begin
				cmd.cmd = fsc_pkg::DC_DENORM;
				state_d = S_ROUND;
			end
			S_ROUND: begin
				cmd.cmd = fsc_pkg::DC_ROUND;
				state_d = S_FINISH;
			end
			S_SPECIAL: begin
				cmd.cmd = fsc_pkg::DC_SPECIAL;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (fire) begin
					cmd.cmd = fsc_pkg::DC_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 5'd1;
			end else begin
				cnt_q <= '0;
			end
			if (fire) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// ===== src/fsc_dp.sv =====
// Datapath of the floating-point stack calculator: stack store, cached top,
// counters, configuration registers and a multi-cycle single-precision unit.
// Depends on fsc_pkg and fsc_ram.
`timescale 1ns / 1ps

module fsc_dp #(
	parameter int STACK_DEPTH = fsc_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          write_en,
	input  logic          write_index,
	input  logic [31:0]   write_data,
	input  logic [2:0]    op,
	input  logic [31:0]   value,
	output logic [31:0]   top_value,
	output logic          negative,
	output logic [3:0]    stack_depth,
	output logic [15:0]   instr_count,
	output logic [1:0]    fault,
	input  fsc_pkg::cmd_t cmd,
	output fsc_pkg::sts_t sts
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int EW = fsc_pkg::EXP_W;
	localparam int MW = fsc_pkg::MANT_W;

	logic [31:0]          x_q, y_q;
	logic [2:0]           op_q;
	logic [31:0]          val_q;
	logic [1:0]           fault_q;
	logic [DW-1:0]        depth_q;
	logic [15:0]          count_q;
	logic [31:0]          top_q;
	logic [31:0]          below;
	logic                 mem_we;

	// Unpacked operands and the working result.
	logic                 sa_q, sb_q;
	logic signed [EW-1:0] ea_q, eb_q;
	logic [23:0]          ma_q, mb_q;
	logic                 special_q;
	logic [31:0]          spec_q;
	logic                 rs_q;
	logic signed [EW-1:0] re_q;
	logic [MW-1:0]        rm_q;
	logic [25:0]          rem_q;
	logic [MW-1:0]        quo_q;

	// Operand classification at start.
	logic                 a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic                 bs_eff, sx;
	logic                 st_special;
	logic [31:0]          st_val;

	// Alignment and add.
	logic                 swap;
	logic signed [EW-1:0] e_l, e_s, e_diff;
	logic [23:0]          m_l, m_s;
	logic                 s_l;
	logic [MW-1:0]        x_s, sh_s;
	logic [MW:0]          sum;
	logic [MW-1:0]        al_mant;
	logic signed [EW-1:0] al_exp;
	logic                 al_sign;

	// Multiply.
	logic [47:0]          prod;

	// Divide step.
	logic [25:0]          rem_sub;
	logic                 q_bit;

	// Denormalize and round.
	logic signed [EW-1:0] dn_sh;
	logic [MW-1:0]        dn_mant;
	logic                 rnd_up;
	logic [24:0]          m25;
	logic [23:0]          mf;
	logic signed [EW-1:0] ef;
	logic [31:0]          rnd_val;

	fsc_ram #(
		.WIDTH (32),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(depth_q - DW'(1))),
		.wdata (top_q),
		.raddr (AW'(depth_q - DW'(2))),
		.rdata (below)
	);

	assign mem_we = (cmd.cmd == fsc_pkg::DC_PUSH) && (depth_q != '0);

	assign sts.op        = op_q;
	assign sts.empty     = (depth_q == '0);
	assign sts.full      = (depth_q == DW'(STACK_DEPTH));
	assign sts.lt2       = (depth_q < DW'(2));
	assign sts.special   = special_q;
	assign sts.pre_done  = ma_q[23] && mb_q[23];
	assign sts.norm_done = (rm_q == '0) || rm_q[MW-1];

	// Classification and special results of below (a) and top (b).
	always_comb begin
		a_nan  = (below[30:23] == 8'hFF) && (below[22:0] != '0);
		b_nan  = (top_q[30:23] == 8'hFF) && (top_q[22:0] != '0);
		a_inf  = (below[30:0] == fsc_pkg::INF_MAG);
		b_inf  = (top_q[30:0] == fsc_pkg::INF_MAG);
		a_zero = (below[30:0] == '0);
		b_zero = (top_q[30:0] == '0);
		bs_eff = top_q[31] ^ (op_q == fsc_pkg::OP_SUB);
		sx     = below[31] ^ top_q[31];
		st_special = 1'b1;
		st_val     = fsc_pkg::QNAN_BITS;
		if (op_q inside {fsc_pkg::OP_ADD, fsc_pkg::OP_SUB}) begin
			if (a_nan || b_nan) begin
				st_val = fsc_pkg::QNAN_BITS;
			end else if (a_inf && b_inf) begin
				st_val = (below[31] != bs_eff) ? fsc_pkg::QNAN_BITS
					: {below[31], fsc_pkg::INF_MAG};
			end else if (a_inf) begin
				st_val = {below[31], fsc_pkg::INF_MAG};
			end else if (b_inf) begin
				st_val = {bs_eff, fsc_pkg::INF_MAG};
			end else begin
				st_special = 1'b0;
			end
		end else if (op_q == fsc_pkg::OP_MUL) begin
			if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
				st_val = fsc_pkg::QNAN_BITS;
			end else if (a_inf || b_inf) begin
				st_val = {sx, fsc_pkg::INF_MAG};
			end else if (a_zero || b_zero) begin
				st_val = {sx, 31'd0};
			end else begin
				st_special = 1'b0;
			end
		end else begin
			if (b_zero) begin
				st_val = (a_nan || a_zero) ? fsc_pkg::QNAN_BITS
					: {sx, fsc_pkg::INF_MAG};
			end else if (a_nan || b_nan || (a_inf && b_inf)) begin
				st_val = fsc_pkg::QNAN_BITS;
			end else if (a_inf) begin
				st_val = {sx, fsc_pkg::INF_MAG};
			end else if (b_inf || a_zero) begin
				st_val = {sx, 31'd0};
			end else begin
				st_special = 1'b0;
			end
		end
	end

	// Alignment of the smaller operand with sticky collection, then add or subtract.
	always_comb begin
		swap   = {eb_q, mb_q} > {ea_q, ma_q};
		e_l    = swap ? eb_q : ea_q;
		e_s    = swap ? ea_q : eb_q;
		m_l    = swap ? mb_q : ma_q;
		m_s    = swap ? ma_q : mb_q;
		s_l    = swap ? sb_q : sa_q;
		e_diff = e_l - e_s;
		x_s    = {m_s, 3'b000};
		if (e_diff >= EW'(MW)) begin
			sh_s = {{(MW-1){1'b0}}, |m_s};
		end else begin
			sh_s    = x_s >> e_diff[4:0];
			sh_s[0] = sh_s[0] | (|(x_s & ~({MW{1'b1}} << e_diff[4:0])));
		end
		if (sa_q == sb_q) begin
			sum = {1'b0, m_l, 3'b000} + {1'b0, sh_s};
		end else begin
			sum = {1'b0, m_l, 3'b000} - {1'b0, sh_s};
		end
		if (sum[MW]) begin
			al_mant = {sum[MW:2], sum[1] | sum[0]};
			al_exp  = e_l + EW'(1);
		end else begin
			al_mant = sum[MW-1:0];
			al_exp  = e_l;
		end
		al_sign = (sum == '0) ? (sa_q & sb_q) : s_l;
	end

	assign prod    = ma_q * mb_q;
	assign q_bit   = (rem_q >= {2'b00, mb_q});
	assign rem_sub = q_bit ? (rem_q - {2'b00, mb_q}) : rem_q;

	// Shift into the subnormal range, then round to nearest even and pack.
	always_comb begin
		dn_sh = EW'(1) - re_q;
		if (dn_sh >= EW'(MW)) begin
			dn_mant = {{(MW-1){1'b0}}, |rm_q};
		end else begin
			dn_mant    = rm_q >> dn_sh[4:0];
			dn_mant[0] = dn_mant[0] | (|(rm_q & ~({MW{1'b1}} << dn_sh[4:0])));
		end
		rnd_up = rm_q[2] && ((|rm_q[1:0]) || rm_q[3]);
		m25    = {1'b0, rm_q[MW-1:3]} + 25'(rnd_up);
		if (m25[24]) begin
			mf = m25[24:1];
			ef = re_q + EW'(1);
		end else begin
			mf = m25[23:0];
			ef = re_q;
		end
		if (ef >= EW'(255)) begin
			rnd_val = {rs_q, fsc_pkg::INF_MAG};
		end else begin
			rnd_val = {rs_q, (mf[23] ? ef[7:0] : 8'd0), mf[22:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= fsc_pkg::X_RESET;
			y_q       <= fsc_pkg::Y_RESET;
			depth_q   <= '0;
			count_q   <= '0;
			fault_q   <= fsc_pkg::FAULT_OK;
			op_q      <= fsc_pkg::OP_NOP;
			special_q <= 1'b0;
		end else begin
			if (write_en) begin
				if (write_index == fsc_pkg::REG_X) begin
					x_q <= write_data;
				end else begin
					y_q <= write_data;
				end
			end
			case (cmd.cmd)
				fsc_pkg::DC_LOAD: begin
					op_q    <= op;
					fault_q <= fsc_pkg::FAULT_OK;
				end
				fsc_pkg::DC_PUSH: begin
					depth_q <= depth_q + DW'(1);
				end
				fsc_pkg::DC_FAULT_OVF: begin
					fault_q <= fsc_pkg::FAULT_OVERFLOW;
				end
				fsc_pkg::DC_FAULT_UNF: begin
					fault_q <= fsc_pkg::FAULT_UNDERFLOW;
				end
				fsc_pkg::DC_START: begin
					special_q <= st_special;
				end
				fsc_pkg::DC_ROUND, fsc_pkg::DC_SPECIAL: begin
					depth_q <= depth_q - DW'(1);
				end
				fsc_pkg::DC_FINISH: begin
					count_q <= count_q + 16'd1;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (cmd.cmd)
			fsc_pkg::DC_LOAD: begin
				val_q <= value;
			end
			fsc_pkg::DC_PUSH: begin
				if (op_q == fsc_pkg::OP_PUSH_VAL) begin
					top_q <= val_q;
				end else if (op_q == fsc_pkg::OP_PUSH_X) begin
					top_q <= x_q;
				end else begin
					top_q <= y_q;
				end
			end
			fsc_pkg::DC_START: begin
				spec_q <= st_val;
				sa_q   <= below[31];
				sb_q   <= bs_eff;
				rs_q   <= sx;
				ea_q   <= (below[30:23] == '0) ? EW'(1) : EW'({1'b0, below[30:23]});
				eb_q   <= (top_q[30:23] == '0) ? EW'(1) : EW'({1'b0, top_q[30:23]});
				ma_q   <= {below[30:23] != '0, below[22:0]};
				mb_q   <= {top_q[30:23] != '0, top_q[22:0]};
			end
			fsc_pkg::DC_PRENORM: begin
				if (!ma_q[23]) begin
					ma_q <= {ma_q[22:0], 1'b0};
					ea_q <= ea_q - EW'(1);
				end
				if (!mb_q[23]) begin
					mb_q <= {mb_q[22:0], 1'b0};
					eb_q <= eb_q - EW'(1);
				end
			end
			fsc_pkg::DC_ALIGN: begin
				rm_q <= al_mant;
				re_q <= al_exp;
				rs_q <= al_sign;
			end
			fsc_pkg::DC_MUL: begin
				rm_q <= {prod[47:22], |prod[21:0]};
				re_q <= ea_q + eb_q - EW'(126);
			end
			fsc_pkg::DC_DIV_INIT: begin
				rem_q <= {2'b00, ma_q};
				quo_q <= '0;
				re_q  <= ea_q - eb_q + EW'(127);
			end
			fsc_pkg::DC_DIV_STEP: begin
				quo_q <= {quo_q[MW-2:0], q_bit};
				rem_q <= {rem_sub[24:0], 1'b0};
			end
			fsc_pkg::DC_DIV_FIN: begin
				rm_q <= {quo_q[MW-1:1], quo_q[0] | (rem_q != '0)};
			end
			fsc_pkg::DC_NORM: begin
				rm_q <= {rm_q[MW-2:0], 1'b0};
				re_q <= re_q - EW'(1);
			end
			fsc_pkg::DC_DENORM: begin
				if (re_q < EW'(1)) begin
					rm_q <= dn_mant;
					re_q <= EW'(1);
				end
			end
			fsc_pkg::DC_ROUND: begin
				top_q <= rnd_val;
			end
			fsc_pkg::DC_SPECIAL: begin
				top_q <= spec_q;
			end
			fsc_pkg::DC_FINISH: begin
				top_value   <= (depth_q != '0) ? top_q : 32'd0;
				negative    <= (depth_q != '0) ? top_q[31] : 1'b0;
				stack_depth <= 4'(depth_q);
				instr_count <= count_q + 16'd1;
				fault       <= fault_q;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/float_stack_calculator.sv =====
// Top level of the floating-point stack calculator.
// Joins the sequencer fsc_ctrl and the datapath fsc_dp. Depends on fsc_pkg.
`timescale 1ns / 1ps

// A stack machine over IEEE-754 single-precision bit patterns. Each input item
// is one instruction: push the immediate value, push the x or y register, or
// pop two entries and push below+top, below-top, below*top or below/top,
// rounded to nearest even with subnormals kept; every NaN result comes out as
// the canonical quiet NaN. Each instruction gives exactly one result item with
// the new top of stack (zero when empty), its sign, the depth, a 16-bit
// running instruction count and a fault code; a faulting instruction leaves
// the stack as it was. The block works on one instruction at a time. An
// operation on special operands (zero, infinity, NaN) takes a short path; an
// add or subtract runs through a one-bit-per-cycle normalizer after
// cancellation; a multiply pre-normalizes subnormal operands one bit per
// cycle; a divide pre-normalizes likewise and then runs a restoring divider
// that produces one quotient bit per cycle. The next instruction can be
// accepted in the cycle after a result has been placed in the output
// register, even while that result is still stalled. The top of stack is
// kept in a register and the entries below it in a small RAM; the registers
// x and y are written through the write port; the user must write them only
// while the block is idle, as the block itself does not enforce it.

module float_stack_calculator #(
	parameter int STACK_DEPTH = fsc_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        write_en,
	input  logic        write_index,
	input  logic [31:0] write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] top_value,
	output logic        negative,
	output logic [3:0]  stack_depth,
	output logic [15:0] instr_count,
	output logic [1:0]  fault
);

	// Command from the sequencer and status back from the datapath.
	fsc_pkg::cmd_t cmd;
	fsc_pkg::sts_t sts;

	fsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fsc_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data),
		.op          (op),
		.value       (value),
		.top_value   (top_value),
		.negative    (negative),
		.stack_depth (stack_depth),
		.instr_count (instr_count),
		.fault       (fault),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
